// ===== hw/rtl/mxt_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the expression tokenizer
package mxt_pkg;

	localparam int CHAR_W     = 8;
	localparam int TOK_MANT_W = 48;
	localparam int FRAC_W     = 4;
	localparam int KIND_W     = 5;
	localparam int STAT_W     = 2;
	localparam int WORD_MAX   = 5;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = 2;
	localparam int QCNT_W     = 3;

	localparam logic [KIND_W-1:0] KIND_NUMBER = 5'd0;
	localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd11;
	localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd12;
	localparam logic [KIND_W-1:0] KIND_TIMES  = 5'd13;
	localparam logic [KIND_W-1:0] KIND_DIVIDE = 5'd14;
	localparam logic [KIND_W-1:0] KIND_POWER  = 5'd15;
	localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd16;
	localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd17;
	localparam logic [KIND_W-1:0] KIND_END    = 5'd18;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_SYNTAX  = 2'd1;
	localparam logic [STAT_W-1:0] ST_KEYWORD = 2'd2;
	localparam logic [STAT_W-1:0] ST_MIXED   = 2'd3;

	localparam logic [1:0] VAR_NONE = 2'd0;

	// keyword indexes, kind is index plus one
	localparam logic [3:0] KW_THETA = 4'd7;
	localparam logic [3:0] KW_NONE  = 4'd10;

	localparam logic [FRAC_W-1:0] FRAC_MAX = 4'd15;

	typedef enum logic [4:0] {
		MODE_IDLE   = 5'b00001,
		MODE_NUMBER = 5'b00010,
		MODE_WORD   = 5'b00100,
		MODE_ERROR  = 5'b01000,
		MODE_MARK   = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [KIND_W-1:0]     token_kind;
		logic [TOK_MANT_W-1:0] number_mantissa;
		logic [FRAC_W-1:0]     fraction_digits;
		logic [STAT_W-1:0]     status;
		logic                  last;
	} token_t;

	typedef struct packed {
		logic   v0;
		logic   v1;
		token_t t0;
		token_t t1;
	} push_t;

	function automatic logic [3:0] kw_match(input logic [WORD_MAX-1:0][7:0] w,
			input logic [2:0] len);
		logic [3:0] k;
		k = KW_NONE;
		if (len == 3'd3 && w[0] == "s" && w[1] == "i" && w[2] == "n") k = 4'd0;
		if (len == 3'd3 && w[0] == "c" && w[1] == "o" && w[2] == "s") k = 4'd1;
		if (len == 3'd3 && w[0] == "t" && w[1] == "a" && w[2] == "n") k = 4'd2;
		if (len == 3'd3 && w[0] == "a" && w[1] == "b" && w[2] == "s") k = 4'd3;
		if (len == 3'd4 && w[0] == "s" && w[1] == "q" && w[2] == "r" && w[3] == "t")
			k = 4'd4;
		if (len == 3'd2 && w[0] == "p" && w[1] == "i") k = 4'd5;
		if (len == 3'd1 && w[0] == "e") k = 4'd6;
		if (len == 3'd5 && w[0] == "t" && w[1] == "h" && w[2] == "e" && w[3] == "t"
				&& w[4] == "a") k = 4'd7;
		if (len == 3'd1 && w[0] == "x") k = 4'd8;
		if (len == 3'd1 && w[0] == "t") k = 4'd9;
		return k;
	endfunction

endpackage

// ===== hw/rtl/mxt_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces of the expression tokenizer
interface mxt_char_if;
	import mxt_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	modport source (output valid, output character, input ready);
	modport sink (input valid, input character, output ready);
endinterface

interface mxt_token_if;
	import mxt_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [KIND_W-1:0]     token_kind;
	logic [TOK_MANT_W-1:0] number_mantissa;
	logic [FRAC_W-1:0]     fraction_digits;
	logic [STAT_W-1:0]     status;
	logic                  last;
	modport source (output valid, output token_kind, output number_mantissa,
		output fraction_digits, output status, output last, input ready);
	modport sink (input valid, input token_kind, input number_mantissa,
		input fraction_digits, input status, input last, output ready);
endinterface

interface mxt_cfg_if;
	logic valid;
	logic ready;
	logic comma_decimal_mark;
	modport source (output valid, output comma_decimal_mark, input ready);
	modport sink (input valid, input comma_decimal_mark, output ready);
endinterface

// ===== hw/rtl/math_expression_tokenizer.sv =====
`timescale 1ns / 1ps
// top level of the arithmetic expression tokenizer
// usage:
//   chars  : one byte per item, a zero byte ends the expression
//   tokens : token items; the end token has last set and carries the status
//   cfg    : one-bit decimal mark select (0 point, 1 comma), write while idle
// tokens of an accepted character enter a four-entry queue at the accepting
// edge and leave one token per cycle while tokens.ready is high. chars takes
// one byte per cycle; ready drops while three or more tokens are held, since
// one byte can end a token and start another. a stalled receiver fills the
// queue and then holds off chars; nothing is lost. tokens come out of the
// lexer state with a word compare in the combinational path.
// reset clears the lexer, the queue and the decimal mark select. after a
// lexical error no tokens come until the zero byte, whose end token carries
// the error.
module math_expression_tokenizer #(
	parameter int MANTISSA_BITS = 48,
	parameter int DEPTH_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	mxt_char_if.sink      chars,
	mxt_token_if.source   tokens,
	mxt_cfg_if.sink       cfg
);
	import mxt_pkg::*;

	logic              mark_q;
	logic              room;
	logic              accept;
	logic [QCNT_W-1:0] level;
	push_t             push;

	assign cfg.ready = 1'b1;
	assign chars.ready = room;
	assign accept = chars.valid && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mark_q <= 1'b0;
		else if (cfg.valid) mark_q <= cfg.comma_decimal_mark;
	end

	mxt_lexer #(
		.MANTISSA_BITS(MANTISSA_BITS),
		.DEPTH_BITS(DEPTH_BITS)
	) u_lexer (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.c(chars.character),
		.comma_mark(mark_q),
		.push(push)
	);

	mxt_token_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.level(level),
		.tokens(tokens)
	);

	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		level <= QCNT_W'(QDEPTH)) else $error("token queue overflow");
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.last |-> tokens.token_kind == KIND_END)
		else $error("last set on a non-end token");
	a_mant: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.token_kind != KIND_NUMBER |->
		tokens.number_mantissa == '0 && tokens.fraction_digits == '0)
		else $error("mantissa on a non-number token");
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0 && !push.t0.last && accept)
		else $error("bad token pair from lexer");

endmodule

// ===== hw/rtl/mxt_lexer.sv =====
`timescale 1ns / 1ps
// front end: character classification and token recognition
module mxt_lexer #(
	parameter int MANTISSA_BITS = 48,
	parameter int DEPTH_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [mxt_pkg::CHAR_W-1:0] c,
	input  logic                    comma_mark,
	output mxt_pkg::push_t          push
);
	import mxt_pkg::*;

	mode_t                         mode_q, mode_n;
	logic [WORD_MAX-1:0][7:0]      letters_q;
	logic [2:0]                    len_q, len_n;
	logic [MANTISSA_BITS-1:0]      acc_q, acc_n;
	logic [FRAC_W-1:0]             frac_q, frac_n;
	logic                          seen_q, seen_n;
	logic [DEPTH_BITS-1:0]         depth_q, depth_n;
	logic                          neg_q, neg_n;
	logic [1:0]                    var_q, var_n;
	logic                          mixed_q, mixed_n;
	logic [STAT_W-1:0]             err_q, err_n;

	logic                          let_we;
	logic [2:0]                    let_idx;
	logic                          is_dig, is_alp, is_sp, is_mark, fall;
	logic [3:0]                    dig, kw;
	logic [MANTISSA_BITS+3:0]      wide;
	logic                          over;
	logic [MANTISSA_BITS+TOK_MANT_W-1:0] mant_ext;
	logic                          emit_a, emit_b;
	token_t                        tok_a, tok_b;
	logic [1:0]                    v;

	assign dig     = c[3:0];
	assign is_dig  = c >= "0" && c <= "9";
	assign is_alp  = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	assign is_sp   = c == " " || (c >= 8'd9 && c <= 8'd13);
	assign is_mark = comma_mark ? (c == ",") : (c == ".");
	// acc * 10 + digit, overflow shows in the top four bits
	assign wide = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ {{MANTISSA_BITS{1'b0}}, dig};
	assign over = |wide[MANTISSA_BITS+3:MANTISSA_BITS];
	assign mant_ext = {{TOK_MANT_W{1'b0}}, acc_q};
	assign kw = kw_match(letters_q, len_q);
	assign v = 2'(kw - 4'd6);

	always_comb begin
		mode_n = mode_q; len_n = len_q; acc_n = acc_q; frac_n = frac_q;
		seen_n = seen_q; depth_n = depth_q; neg_n = neg_q; var_n = var_q;
		mixed_n = mixed_q; err_n = err_q;
		let_we = 1'b0; let_idx = len_q;
		emit_a = 1'b0; emit_b = 1'b0; tok_a = '0; tok_b = '0;
		fall = 1'b1;
		if (accept) begin
			case (mode_q)
				MODE_MARK, MODE_NUMBER: begin
					if (is_dig) begin
						mode_n = MODE_NUMBER;
						fall = 1'b0;
						if (!seen_q) begin
							acc_n = over ? '1 : wide[MANTISSA_BITS-1:0];
						end else if (!over && frac_q < FRAC_MAX) begin
							acc_n = wide[MANTISSA_BITS-1:0];
							frac_n = frac_q + 4'd1;
						end
					end else if (mode_q == MODE_MARK) begin
						if (err_q == ST_OK) err_n = ST_SYNTAX;
						mode_n = MODE_ERROR;
					end else if (is_mark && !seen_q) begin
						seen_n = 1'b1;
						fall = 1'b0;
					end else begin
						emit_a = 1'b1;
						tok_a.token_kind = KIND_NUMBER;
						tok_a.number_mantissa = mant_ext[TOK_MANT_W-1:0];
						tok_a.fraction_digits = frac_q;
						mode_n = MODE_IDLE;
					end
				end
				MODE_WORD: begin
					if (is_alp || is_dig) begin
						fall = 1'b0;
						let_we = len_q < 3'd5;
						if (len_q < 3'd6) len_n = len_q + 3'd1;
					end else begin
						mode_n = MODE_IDLE;
						if (kw == KW_NONE) begin
							if (err_q == ST_OK) err_n = ST_KEYWORD;
							mode_n = MODE_ERROR;
						end else begin
							if (kw >= KW_THETA) begin
								if (var_q == VAR_NONE) var_n = v;
								else if (var_q != v) mixed_n = 1'b1;
							end
							emit_a = 1'b1;
							tok_a.token_kind = KIND_W'(kw + 4'd1);
						end
					end
				end
				default: ;
			endcase
			if (fall) begin
				if (c == '0) begin
					emit_b = 1'b1;
					tok_b.token_kind = KIND_END;
					tok_b.last = 1'b1;
					if (err_n != ST_OK) tok_b.status = err_n;
					else if (mixed_n) tok_b.status = ST_MIXED;
					else if (depth_q != '0 || neg_q) tok_b.status = ST_SYNTAX;
					else tok_b.status = ST_OK;
					mode_n = MODE_IDLE; len_n = '0; acc_n = '0; frac_n = '0;
					seen_n = 1'b0; depth_n = '0; neg_n = 1'b0; var_n = VAR_NONE;
					mixed_n = 1'b0; err_n = ST_OK;
				end else if (mode_n != MODE_ERROR) begin
					mode_n = MODE_IDLE;
					if (is_sp) begin
					end else if (is_dig) begin
						mode_n = MODE_NUMBER;
						acc_n = {{(MANTISSA_BITS-4){1'b0}}, dig};
						frac_n = '0;
						seen_n = 1'b0;
					end else if (is_mark) begin
						mode_n = MODE_MARK;
						acc_n = '0;
						frac_n = '0;
						seen_n = 1'b1;
					end else if (is_alp) begin
						mode_n = MODE_WORD;
						let_we = 1'b1;
						let_idx = '0;
						len_n = 3'd1;
					end else begin
						emit_b = 1'b1;
						case (c)
							"+": tok_b.token_kind = KIND_PLUS;
							"-": tok_b.token_kind = KIND_MINUS;
							"*": tok_b.token_kind = KIND_TIMES;
							"/": tok_b.token_kind = KIND_DIVIDE;
							"^": tok_b.token_kind = KIND_POWER;
							"(": begin
								tok_b.token_kind = KIND_LPAREN;
								if (&depth_q) neg_n = 1'b1;
								else depth_n = depth_q + 1'b1;
							end
							")": begin
								tok_b.token_kind = KIND_RPAREN;
								if (depth_q == '0) neg_n = 1'b1;
								else depth_n = depth_q - 1'b1;
							end
							default: begin
								emit_b = 1'b0;
								if (err_q == ST_OK) err_n = ST_SYNTAX;
								mode_n = MODE_ERROR;
							end
						endcase
					end
				end
			end
		end
	end

	always_comb begin
		push = '0;
		if (emit_a) begin
			push.v0 = 1'b1;
			push.t0 = tok_a;
			push.v1 = emit_b;
			push.t1 = tok_b;
		end else begin
			push.v0 = emit_b;
			push.t0 = tok_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE; len_q <= '0; acc_q <= '0; frac_q <= '0;
			seen_q <= 1'b0; depth_q <= '0; neg_q <= 1'b0; var_q <= VAR_NONE;
			mixed_q <= 1'b0; err_q <= ST_OK;
		end else begin
			mode_q <= mode_n; len_q <= len_n; acc_q <= acc_n; frac_q <= frac_n;
			seen_q <= seen_n; depth_q <= depth_n; neg_q <= neg_n; var_q <= var_n;
			mixed_q <= mixed_n; err_q <= err_n;
		end
	end

	always_ff @(posedge clk) begin
		if (let_we) letters_q[let_idx] <= c;
	end

endmodule

// ===== hw/rtl/mxt_token_queue.sv =====
`timescale 1ns / 1ps
// back end: token queue with two-wide push that drives the output channel
module mxt_token_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mxt_pkg::push_t             push,
	output logic                       room,
	output logic [mxt_pkg::QCNT_W-1:0] level,
	mxt_token_if.source                tokens
);
	import mxt_pkg::*;

	token_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   head_q, tail_q, tail1;
	logic [QCNT_W-1:0]   cnt_q;
	logic                pop;
	logic [1:0]          npush;

	assign tail1 = tail_q + 1'b1;
	assign pop = tokens.valid && tokens.ready;
	assign npush = {1'b0, push.v0} + {1'b0, push.v1};
	// room for two tokens from the next item
	assign room = cnt_q <= QCNT_W'(QDEPTH - 2);
	assign level = cnt_q;

	assign tokens.valid           = cnt_q != '0;
	assign tokens.token_kind      = mem_q[head_q].token_kind;
	assign tokens.number_mantissa = mem_q[head_q].number_mantissa;
	assign tokens.fraction_digits = mem_q[head_q].fraction_digits;
	assign tokens.status          = mem_q[head_q].status;
	assign tokens.last            = mem_q[head_q].last;

	always_ff @(posedge clk) begin
		if (push.v0) mem_q[tail_q] <= push.t0;
		if (push.v1) mem_q[tail1] <= push.t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
		end else begin
			if (pop) head_q <= head_q + 1'b1;
			tail_q <= tail_q + QPTR_W'(npush);
			cnt_q <= cnt_q + QCNT_W'(npush) - QCNT_W'(pop);
		end
	end

endmodule

// ===== verif/math_expression_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the arithmetic expression tokenizer
module math_expression_tokenizer_tb;
	import mxt_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD  = 300;
	localparam logic [63:0] MANT_SAT = 64'h0000_FFFF_FFFF_FFFF;
	localparam logic [7:0] DEPTH_TOP = 8'hFF;

	logic clk;
	logic arst_n;

	mxt_char_if  chars ();
	mxt_token_if tokens ();
	mxt_cfg_if   cfg ();

	math_expression_tokenizer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars.sink),
		.tokens (tokens.source),
		.cfg    (cfg.sink)
	);

	always #5 clk = ~clk;

	// lexer state mirror
	mode_t       lx_mode;
	logic [7:0]  lx_letters [WORD_MAX];
	logic [2:0]  lx_len;
	logic [63:0] lx_mant;
	logic [3:0]  lx_frac;
	logic        lx_seen_mark;
	logic [7:0]  lx_depth;
	logic        lx_unbalanced;
	logic [1:0]  lx_var;
	logic        lx_mixed;
	logic [1:0]  lx_err;
	logic        comma_sel;

	token_t expected_tokens [$];
	string  keyword_names [10] = '{"sin", "cos", "tan", "abs", "sqrt", "pi", "e", "theta",
		"x", "t"};

	bit quiet;
	int hold_left;
	int fail_count;
	int chars_sent;
	int tokens_checked;
	int expr_count;
	int idle_cycles;

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	task automatic push_token(logic [KIND_W-1:0] kind, logic [63:0] mant, logic [3:0] frac,
			logic [STAT_W-1:0] st, logic lst);
		token_t t;
		t.token_kind = kind;
		t.number_mantissa = mant[TOK_MANT_W-1:0];
		t.fraction_digits = frac;
		t.status = st;
		t.last = lst;
		expected_tokens.push_back(t);
	endtask

	task automatic clear_lexer();
		lx_mode = MODE_IDLE;
		lx_len = 0;
		lx_mant = 0;
		lx_frac = 0;
		lx_seen_mark = 0;
		lx_depth = 0;
		lx_unbalanced = 0;
		lx_var = VAR_NONE;
		lx_mixed = 0;
		lx_err = ST_OK;
	endtask

	task automatic flag_error(logic [1:0] code);
		if (lx_err == ST_OK)
			lx_err = code;
		lx_mode = MODE_ERROR;
	endtask

	task automatic add_digit(logic [7:0] c);
		logic [63:0] d;
		bit over;
		d = 64'(c - "0");
		over = lx_mant > (MANT_SAT - d) / 10;
		if (!lx_seen_mark) begin
			lx_mant = over ? MANT_SAT : lx_mant * 10 + d;
		end else if (!over && lx_frac < FRAC_MAX) begin
			lx_mant = lx_mant * 10 + d;
			lx_frac++;
		end
	endtask

	task automatic close_word();
		int k;
		int hit;
		hit = 10;
		lx_mode = MODE_IDLE;
		for (k = 9; k >= 0; k--) begin
			if (lx_len == keyword_names[k].len()) begin
				bit same;
				same = 1;
				for (int i = 0; i < lx_len; i++)
					if (lx_letters[i] != keyword_names[k][i])
						same = 0;
				if (same)
					hit = k;
			end
		end
		if (hit == 10) begin
			flag_error(ST_KEYWORD);
			return;
		end
		if (hit >= KW_THETA) begin
			if (lx_var == VAR_NONE)
				lx_var = 2'(hit - 6);
			else if (lx_var != 2'(hit - 6))
				lx_mixed = 1;
		end
		push_token(KIND_W'(hit + 1), 0, 0, ST_OK, 0);
	endtask

	task automatic start_token(logic [7:0] c, logic [7:0] mark);
		if (c == " " || (c >= 8'd9 && c <= 8'd13))
			return;
		if (is_digit(c)) begin
			lx_mode = MODE_NUMBER;
			lx_mant = 0;
			lx_frac = 0;
			lx_seen_mark = 0;
			add_digit(c);
		end else if (c == mark) begin
			lx_mode = MODE_MARK;
			lx_mant = 0;
			lx_frac = 0;
			lx_seen_mark = 1;
		end else if (is_alpha(c)) begin
			lx_mode = MODE_WORD;
			lx_letters[0] = c;
			lx_len = 1;
		end else begin
			case (c)
				"+": push_token(KIND_PLUS, 0, 0, ST_OK, 0);
				"-": push_token(KIND_MINUS, 0, 0, ST_OK, 0);
				"*": push_token(KIND_TIMES, 0, 0, ST_OK, 0);
				"/": push_token(KIND_DIVIDE, 0, 0, ST_OK, 0);
				"^": push_token(KIND_POWER, 0, 0, ST_OK, 0);
				"(": begin
					if (lx_depth == DEPTH_TOP)
						lx_unbalanced = 1;
					else
						lx_depth++;
					push_token(KIND_LPAREN, 0, 0, ST_OK, 0);
				end
				")": begin
					if (lx_depth == 0)
						lx_unbalanced = 1;
					else
						lx_depth--;
					push_token(KIND_RPAREN, 0, 0, ST_OK, 0);
				end
				default: flag_error(ST_SYNTAX);
			endcase
		end
	endtask

	// tokens caused by one accepted character
	task automatic predict_tokens(logic [7:0] c);
		logic [7:0] mark;
		logic [1:0] st;
		mark = comma_sel ? "," : ".";
		case (lx_mode)
			MODE_MARK: begin
				if (is_digit(c)) begin
					lx_mode = MODE_NUMBER;
					add_digit(c);
					return;
				end
				flag_error(ST_SYNTAX);
			end
			MODE_NUMBER: begin
				if (is_digit(c)) begin
					add_digit(c);
					return;
				end
				if (c == mark && !lx_seen_mark) begin
					lx_seen_mark = 1;
					return;
				end
				push_token(KIND_NUMBER, lx_mant, lx_frac, ST_OK, 0);
				lx_mode = MODE_IDLE;
			end
			MODE_WORD: begin
				if (is_alpha(c) || is_digit(c)) begin
					if (lx_len < 5)
						lx_letters[lx_len] = c;
					if (lx_len < 6)
						lx_len++;
					return;
				end
				close_word();
			end
			default: ;
		endcase
		if (c == 8'd0) begin
			if (lx_err != ST_OK)
				st = lx_err;
			else if (lx_mixed)
				st = ST_MIXED;
			else if (lx_depth != 0 || lx_unbalanced)
				st = ST_SYNTAX;
			else
				st = ST_OK;
			push_token(KIND_END, 0, 0, st, 1);
			clear_lexer();
			expr_count++;
			return;
		end
		if (lx_mode == MODE_ERROR)
			return;
		lx_mode = MODE_IDLE;
		start_token(c, mark);
	endtask

	task automatic send_char(logic [7:0] c);
		chars.valid <= 1'b1;
		chars.character <= c;
		do
			@(posedge clk);
		while (!chars.ready);
		predict_tokens(c);
		chars_sent++;
		if (!quiet && $urandom_range(0, 6) == 0) begin
			chars.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic send_expr(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
		send_char(8'd0);
	endtask

	task automatic drain();
		chars.valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mark(logic sel);
		drain();
		cfg.valid <= 1'b1;
		cfg.comma_decimal_mark <= sel;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		comma_sel = sel;
	endtask

	task automatic test_directed();
		send_expr("sin(x)+cos(x)*tan(x)-abs(x)/sqrt(x)^pi e");
		send_expr("theta t");
		send_expr("((1)");
		send_expr(")(");
		send_expr("3.14.15");
		send_expr(".5+.");
		send_expr(".a");
		send_expr("abcdef+1");
		send_expr("Sin");
		send_expr("1#2");
		send_expr("\t\n\v\f\r 7 ");
		send_expr("99999999999999999999");
		send_expr("1.00000000000000000009");
		send_expr("");
		send_expr("12");
		send_expr("x");
		send_char(8'd200);
		send_char(8'd255);
		send_char(8'd0);
		send_expr("2,5");
	endtask

	task automatic test_comma_mark();
		set_mark(1'b1);
		send_expr("3,25+,5 1.2");
		send_expr("4,5,6*,");
		send_expr("x^2,");
		set_mark(1'b0);
		send_expr("3,25+.5");
	endtask

	task automatic test_nesting_overflow();
		for (int i = 0; i < 258; i++)
			send_char("(");
		for (int i = 0; i < 255; i++)
			send_char(")");
		send_char(8'd0);
	endtask

	task automatic send_random_expr();
		string s;
		string ops;
		int n;
		int v;
		s = "";
		ops = "+-*/^";
		v = $urandom_range(0, 9);
		n = $urandom_range(1, 9);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 11))
				0, 1, 2: begin
					int len;
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 22)
						: $urandom_range(1, 4);
					if ($urandom_range(0, 7) == 0)
						s = {s, comma_sel ? "," : "."};
					for (int j = 0; j < len; j++) begin
						s = {s, string'(8'("0" + $urandom_range(0, 9)))};
						if ($urandom_range(0, 5) == 0)
							s = {s, comma_sel ? "," : "."};
					end
				end
				3, 4: s = {s, keyword_names[$urandom_range(0, 6)]};
				5: s = {s, keyword_names[(v < 7) ? 7 + v % 3 : $urandom_range(7, 9)]};
				6, 7: s = {s, string'(ops[$urandom_range(0, 4)])};
				8: s = {s, ($urandom_range(0, 1) != 0) ? "(" : ")"};
				9: s = {s, " "};
				10: begin
					int len;
					len = $urandom_range(1, 7);
					for (int j = 0; j < len; j++)
						s = {s, string'(8'("a" + $urandom_range(0, 25)))};
				end
				default: s = {s, string'(8'($urandom_range(1, 255)))};
			endcase
			if ($urandom_range(0, 2) == 0)
				s = {s, " "};
		end
		send_expr(s);
	endtask

	task automatic test_random_expressions();
		int phase;
		phase = 0;
		while (chars_sent < 1150) begin
			set_mark(phase == 0 ? 1'b0 : phase == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
			repeat (25) send_random_expr();
			phase++;
		end
	endtask

	task automatic test_long_stall();
		drain();
		hold_left = LONG_HOLD;
		repeat (8) send_expr("1+2*(3)");
	endtask

	task automatic test_no_idling();
		drain();
		quiet = 1;
		repeat (6) send_random_expr();
		send_expr("sqrt(x)^2-x");
	endtask

	// receiver side with random stall bursts, a long hold and an always-ready mode
	initial begin
		int burst;
		bit stall;
		burst = 0;
		tokens.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				tokens.ready <= 1'b0;
				hold_left--;
			end else if (quiet) begin
				tokens.ready <= 1'b1;
			end else if (burst == 0) begin
				stall = ($urandom_range(0, 3) == 0);
				burst = stall ? $urandom_range(1, 11) : $urandom_range(1, 24);
				tokens.ready <= !stall;
			end else begin
				burst--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && tokens.valid && tokens.ready) begin
			token_t want;
			if (expected_tokens.size() == 0) begin
				$error("token with no expectation: kind %0d", tokens.token_kind);
				fail_count++;
			end else begin
				want = expected_tokens.pop_front();
				tokens_checked++;
				if (tokens.token_kind !== want.token_kind) begin
					$error("token_kind: expected %0d actual %0d", want.token_kind,
						tokens.token_kind);
					fail_count++;
				end
				if (tokens.number_mantissa !== want.number_mantissa) begin
					$error("number_mantissa: expected %0d actual %0d", want.number_mantissa,
						tokens.number_mantissa);
					fail_count++;
				end
				if (tokens.fraction_digits !== want.fraction_digits) begin
					$error("fraction_digits: expected %0d actual %0d", want.fraction_digits,
						tokens.fraction_digits);
					fail_count++;
				end
				if (tokens.status !== want.status) begin
					$error("status: expected %0d actual %0d", want.status, tokens.status);
					fail_count++;
				end
				if (tokens.last !== want.last) begin
					$error("last: expected %0d actual %0d", want.last, tokens.last);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no item moving anywhere
	always @(posedge clk) begin
		if ((chars.valid && chars.ready) || (tokens.valid && tokens.ready)
				|| (cfg.valid && cfg.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL math_expression_tokenizer");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		chars.valid = 1'b0;
		chars.character = 8'd0;
		cfg.valid = 1'b0;
		cfg.comma_decimal_mark = 1'b0;
		quiet = 0;
		hold_left = 0;
		fail_count = 0;
		chars_sent = 0;
		tokens_checked = 0;
		expr_count = 0;
		idle_cycles = 0;
		comma_sel = 1'b0;
		clear_lexer();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_comma_mark();
		test_nesting_overflow();
		test_random_expressions();
		test_long_stall();
		test_no_idling();

		drain();
		repeat (10) @(posedge clk);
		$display("covered %0d characters in %0d expressions, %0d tokens checked",
			chars_sent, expr_count, tokens_checked);
		$display("both decimal marks, errors, saturation, deep nesting and a long stall");
		if (fail_count == 0)
			$display("PASS math_expression_tokenizer");
		else
			$display("FAIL math_expression_tokenizer");
		$finish;
	end

endmodule
